// ----- sv/nfpa_pkg.sv -----
// Shared types and constants of the next-fit pool allocator.
`timescale 1ns / 1ps
package nfpa_pkg;

  localparam int POOL_BYTES   = 4096;
  localparam int HEADER_BYTES = 16;
  localparam int OFF_W        = $clog2(POOL_BYTES);
  localparam int SIZE_W       = OFF_W;
  localparam int LEN_W        = 13;
  localparam int HDR_W        = OFF_W + 1 + SIZE_W + 1;
  localparam int CFG_IDX_W    = 2;

  localparam logic [1:0] KIND_INIT     = 2'd0;
  localparam logic [1:0] KIND_ALLOC    = 2'd1;
  localparam logic [1:0] KIND_RELEASE  = 2'd2;
  localparam logic [1:0] KIND_SHUTDOWN = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FAIL      = 2'd1;
  localparam logic [1:0] ST_NOT_READY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BYTES = 2'd1;

  typedef struct packed {
    logic [OFF_W-1:0]  next;
    logic              next_null;
    logic [SIZE_W-1:0] size;
    logic              is_free;
  } hdr_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [LEN_W-1:0] request_size;
    logic [31:0]      release_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_address;
  } rsp_t;

endpackage

// ----- sv/nfpa_ram.sv -----
// Header memory with one write port, one read port and registered read data.
`timescale 1ns / 1ps
module nfpa_ram #(
  parameter int Depth = 4096,
  parameter int Width = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write, and read through a register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- sv/next_fit_pool_allocator.sv -----
// Next-fit pool allocator: a walker over block headers held in one memory.
// Init, shut down, rejected and not-ready requests answer in the cycle after start.
// Allocate and release answer once the walk over the blocks it needs is through;
// the chain walk reads one header per cycle through the memory's single read port.
// One item at a time; the result strobe lasts one cycle and cannot be stalled.
// Reset clears pool ready and the rover; header memory holds no reset and needs no clearing.
`timescale 1ns / 1ps
module next_fit_pool_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  nfpa_pkg::req_t                  req_i,
  output logic                            done_o,
  output nfpa_pkg::rsp_t                  rsp_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [nfpa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_A_ROV  = 8'b0000_0010,
    S_A_CHK  = 8'b0000_0100,
    S_A_WCUR = 8'b0000_1000,
    S_R_CHK  = 8'b0001_0000,
    S_R_HIT  = 8'b0010_0000,
    S_R_NX   = 8'b0100_0000,
    S_R_PREV = 8'b1000_0000
  } state_e;

  localparam int OW = nfpa_pkg::OFF_W;
  localparam int SW = nfpa_pkg::SIZE_W;
  localparam int LW = nfpa_pkg::LEN_W;
  localparam logic [SW-1:0] HdrSize = SW'(nfpa_pkg::HEADER_BYTES);

  state_e state_q, state_d;
  logic [31:0] base_q;
  logic [LW-1:0] bytes_q;
  logic ready_q, ready_d;
  logic rov_valid_q, rov_valid_d;
  logic [OW-1:0] rov_q, rov_d;
  logic [OW-1:0] cur_q, cur_d, start_q, start_d, prev_q, prev_d, off_q, off_d, nx_q, nx_d;
  logic [OW:0] nb_q, nb_d;
  logic start_valid_q, start_valid_d, have_prev_q, have_prev_d, split_q, split_d;
  logic [LW-1:0] req_q, req_d;
  nfpa_pkg::hdr_t hold_q, hold_d, prev_hdr_q, prev_hdr_d;
  logic done_q, done_d;
  nfpa_pkg::rsp_t rsp_q, rsp_d;

  logic we;
  logic [OW-1:0] waddr, raddr;
  nfpa_pkg::hdr_t wdata, rdata;
  logic accept;

  logic [LW-1:0] clamp;
  logic [31:0] rel_off;
  logic fits, nxt_valid, walk_end;
  logic [OW-1:0] nxt;
  logic [SW-1:0] rem;
  logic [OW+1:0] nb_sum;

  assign accept      = start & ~busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  nfpa_ram #(
    .Depth(nfpa_pkg::POOL_BYTES),
    .Width(nfpa_pkg::HDR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Split arithmetic and walk step on the header just read
  always_comb begin
    clamp     = (bytes_q > LW'(nfpa_pkg::POOL_BYTES)) ? LW'(nfpa_pkg::POOL_BYTES) : bytes_q;
    rel_off   = req_i.release_address - base_q - 32'(nfpa_pkg::HEADER_BYTES);
    fits      = rdata.is_free && ({1'b0, rdata.size} >= req_q);
    rem       = rdata.size - req_q[SW-1:0];
    nb_sum    = (OW+2)'(cur_q) + (OW+2)'(nfpa_pkg::HEADER_BYTES) + (OW+2)'(req_q);
    nxt_valid = ~rdata.next_null;
    nxt       = nxt_valid ? rdata.next : '0;
    walk_end  = (nxt_valid == start_valid_q) && (!nxt_valid || nxt == start_q);
  end

  // Sequence one request through the header memory
  always_comb begin
    state_d       = state_q;
    ready_d       = ready_q;
    rov_valid_d   = rov_valid_q;
    rov_d         = rov_q;
    cur_d         = cur_q;
    start_d       = start_q;
    start_valid_d = start_valid_q;
    prev_d        = prev_q;
    have_prev_d   = have_prev_q;
    off_d         = off_q;
    nx_d          = nx_q;
    nb_d          = nb_q;
    split_d       = split_q;
    req_d         = req_q;
    hold_d        = hold_q;
    prev_hdr_d    = prev_hdr_q;
    done_d        = 1'b0;
    rsp_d         = rsp_q;
    we            = 1'b0;
    waddr         = cur_q;
    wdata         = hold_q;
    raddr         = cur_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d               = 1'b1;
          rsp_d.status         = nfpa_pkg::ST_OK;
          rsp_d.result_address = '0;
          req_d                = req_i.request_size;
          case (req_i.kind)
            nfpa_pkg::KIND_INIT: begin
              if (base_q == '0 || clamp <= LW'(nfpa_pkg::HEADER_BYTES)) begin
                rsp_d.status = nfpa_pkg::ST_FAIL;
              end else begin
                we              = 1'b1;
                waddr           = '0;
                wdata.next      = '0;
                wdata.next_null = 1'b1;
                wdata.size      = SW'(clamp - LW'(nfpa_pkg::HEADER_BYTES));
                wdata.is_free   = 1'b1;
                rov_d           = '0;
                rov_valid_d     = 1'b1;
                ready_d         = 1'b1;
              end
            end
            nfpa_pkg::KIND_SHUTDOWN: begin
              ready_d     = 1'b0;
              rov_valid_d = 1'b0;
              rov_d       = '0;
            end
            default: begin
              if (!ready_q) begin
                rsp_d.status = nfpa_pkg::ST_NOT_READY;
              end else if (req_i.kind == nfpa_pkg::KIND_ALLOC) begin
                if (req_i.request_size == '0) begin
                  rsp_d.status = nfpa_pkg::ST_FAIL;
                end else if (rov_valid_q) begin
                  done_d  = 1'b0;
                  raddr   = rov_q;
                  state_d = S_A_ROV;
                end else begin
                  done_d        = 1'b0;
                  cur_d         = '0;
                  start_d       = '0;
                  start_valid_d = 1'b1;
                  raddr         = '0;
                  state_d       = S_A_CHK;
                end
              end else if (req_i.release_address == '0) begin
                rsp_d.status = nfpa_pkg::ST_OK;
              end else if (rel_off >= 32'(nfpa_pkg::POOL_BYTES)) begin
                rsp_d.status = nfpa_pkg::ST_FAIL;
              end else begin
                done_d      = 1'b0;
                off_d       = rel_off[OW-1:0];
                cur_d       = '0;
                have_prev_d = 1'b0;
                raddr       = '0;
                state_d     = (rel_off[OW-1:0] == '0) ? S_R_HIT : S_R_CHK;
              end
            end
          endcase
        end
      end
      S_A_ROV: begin
        // Start the search at the block after the rover
        start_valid_d = nxt_valid;
        start_d       = nxt;
        cur_d         = nxt;
        raddr         = nxt;
        state_d       = S_A_CHK;
      end
      S_A_CHK: begin
        if (fits) begin
          hold_d  = rdata;
          nb_d    = nb_sum[OW:0];
          split_d = (rem >= HdrSize) && (nb_sum < (OW+2)'(nfpa_pkg::POOL_BYTES));
          if ((rem >= HdrSize) && (nb_sum < (OW+2)'(nfpa_pkg::POOL_BYTES))) begin
            we              = 1'b1;
            waddr           = nb_sum[OW-1:0];
            wdata.next      = rdata.next;
            wdata.next_null = rdata.next_null;
            wdata.size      = rem - HdrSize;
            wdata.is_free   = 1'b1;
          end
          state_d = S_A_WCUR;
        end else if (walk_end) begin
          done_d               = 1'b1;
          rsp_d.status         = nfpa_pkg::ST_FAIL;
          rsp_d.result_address = '0;
          state_d              = S_IDLE;
        end else begin
          cur_d = nxt;
          raddr = nxt;
        end
      end
      S_A_WCUR: begin
        // Claim the found block and move the rover onto it
        we            = 1'b1;
        waddr         = cur_q;
        wdata         = hold_q;
        wdata.is_free = 1'b0;
        if (split_q) begin
          wdata.size      = req_q[SW-1:0];
          wdata.next      = nb_q[OW-1:0];
          wdata.next_null = 1'b0;
        end
        rov_d                = cur_q;
        rov_valid_d          = 1'b1;
        done_d               = 1'b1;
        rsp_d.status         = nfpa_pkg::ST_OK;
        rsp_d.result_address = base_q + 32'(cur_q) + 32'(nfpa_pkg::HEADER_BYTES);
        state_d              = S_IDLE;
      end
      S_R_CHK: begin
        if (rdata.next_null) begin
          done_d               = 1'b1;
          rsp_d.status         = nfpa_pkg::ST_FAIL;
          rsp_d.result_address = '0;
          state_d              = S_IDLE;
        end else begin
          prev_d      = cur_q;
          prev_hdr_d  = rdata;
          have_prev_d = 1'b1;
          cur_d       = rdata.next;
          raddr       = rdata.next;
          if (rdata.next == off_q) begin
            state_d = S_R_HIT;
          end
        end
      end
      S_R_HIT: begin
        if (rdata.is_free) begin
          done_d               = 1'b1;
          rsp_d.status         = nfpa_pkg::ST_FAIL;
          rsp_d.result_address = '0;
          state_d              = S_IDLE;
        end else begin
          hold_d         = rdata;
          hold_d.is_free = 1'b1;
          if (!rdata.next_null) begin
            nx_d    = rdata.next;
            raddr   = rdata.next;
            state_d = S_R_NX;
          end else begin
            state_d = S_R_PREV;
          end
        end
      end
      S_R_NX: begin
        // Absorb a free next block
        if (rdata.is_free) begin
          hold_d.size      = hold_q.size + rdata.size + HdrSize;
          hold_d.next      = rdata.next;
          hold_d.next_null = rdata.next_null;
          if (rov_valid_q && rov_q == nx_q) begin
            rov_d = off_q;
          end
        end
        state_d = S_R_PREV;
      end
      S_R_PREV: begin
        // Fold into a free previous block, else write the released block back
        we = 1'b1;
        if (have_prev_q && prev_hdr_q.is_free) begin
          waddr           = prev_q;
          wdata           = prev_hdr_q;
          wdata.size      = prev_hdr_q.size + hold_q.size + HdrSize;
          wdata.next      = hold_q.next;
          wdata.next_null = hold_q.next_null;
          if (rov_valid_q && rov_q == off_q) begin
            rov_d = prev_q;
          end
        end else begin
          waddr = off_q;
          wdata = hold_q;
        end
        done_d               = 1'b1;
        rsp_d.status         = nfpa_pkg::ST_OK;
        rsp_d.result_address = '0;
        state_d              = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_q     <= 1'b0;
      rov_valid_q <= 1'b0;
      rov_q       <= '0;
      done_q      <= 1'b0;
      base_q      <= '0;
      bytes_q     <= '0;
    end else begin
      state_q     <= state_d;
      ready_q     <= ready_d;
      rov_valid_q <= rov_valid_d;
      rov_q       <= rov_d;
      done_q      <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == nfpa_pkg::CFG_POOL_BASE) begin
          base_q <= cfg_data_i;
        end else if (cfg_index_i == nfpa_pkg::CFG_POOL_BYTES) begin
          bytes_q <= cfg_data_i[LW-1:0];
        end
      end
    end
  end

  // Walk and result payload
  always_ff @(posedge clk_i) begin
    cur_q         <= cur_d;
    start_q       <= start_d;
    start_valid_q <= start_valid_d;
    prev_q        <= prev_d;
    have_prev_q   <= have_prev_d;
    off_q         <= off_d;
    nx_q          <= nx_d;
    nb_q          <= nb_d;
    split_q       <= split_d;
    req_q         <= req_d;
    hold_q        <= hold_d;
    prev_hdr_q    <= prev_hdr_d;
    rsp_q         <= rsp_d;
  end

`ifndef SYNTH
  a_write_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (busy || accept))
    else $error("header write outside a request");
  a_rover_needs_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_q |-> !rov_valid_q)
    else $error("rover valid on a pool that is not ready");
  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("walk began without a start beat");
  a_done_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !$past(busy) && done_o) |-> 1'b0)
    else $error("result beat while a walk was starting");
`endif

endmodule
